// ===== design/tftp_server_session_defines.svh =====
// ----------------------------------------------------------------------------
// TFTP server session: assertion macros
// Shared helpers for the concurrent checks on the session block.
// ----------------------------------------------------------------------------
`ifndef TFTP_SERVER_SESSION_DEFINES_SVH
`define TFTP_SERVER_SESSION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tftp session check failed");

// The consequent must hold in the cycle after the antecedent.
`define TSS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tftp session check failed");

`endif

// ===== design/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// TFTP server session package
// Codes, classified item and result types shared by the session modules.
// ----------------------------------------------------------------------------
package tss_pkg;

	// Action taken for one item.
	typedef enum logic [2:0] {
		ACT_NONE   = 3'd0,
		ACT_ACK    = 3'd1,
		ACT_DATA   = 3'd2,
		ACT_RESEND = 3'd3,
		ACT_ERROR  = 3'd4
	} action_t;

	// Internal reason behind an ERROR packet.
	typedef enum logic [3:0] {
		WHY_NONE        = 4'd0,
		WHY_BUSY        = 4'd1,
		WHY_NAME_LONG   = 4'd2,
		WHY_MODE_LONG   = 4'd3,
		WHY_OPEN_FAIL   = 4'd4,
		WHY_READ_FAIL   = 4'd5,
		WHY_NO_SESSION  = 4'd6,
		WHY_NOT_WRITE   = 4'd7,
		WHY_WRITE_FAIL  = 4'd8,
		WHY_NOT_READ    = 4'd9,
		WHY_WRONG_BLOCK = 4'd10,
		WHY_UNKNOWN_OP  = 4'd11
	} reason_t;

	// Wire error codes.
	localparam logic [2:0] ECODE_NOT_FOUND  = 3'd1;
	localparam logic [2:0] ECODE_ACCESS     = 3'd2;
	localparam logic [2:0] ECODE_ILLEGAL    = 3'd4;
	localparam logic [2:0] ECODE_UNKNOWN_ID = 3'd5;

	// Packet opcodes.
	localparam logic [15:0] OP_RRQ  = 16'd1;
	localparam logic [15:0] OP_WRQ  = 16'd2;
	localparam logic [15:0] OP_DATA = 16'd3;
	localparam logic [15:0] OP_ACK  = 16'd4;

	// Request string check codes.
	localparam logic [1:0] FORM_OK        = 2'd0;
	localparam logic [1:0] FORM_NAME_LONG = 2'd1;

	// Configuration register indexes.
	localparam logic CFG_TIMEOUT = 1'b0;
	localparam logic CFG_RETRY   = 1'b1;

	// Packet class found by the front end.
	typedef enum logic [2:0] {
		KIND_RRQ     = 3'd0,
		KIND_WRQ     = 3'd1,
		KIND_DATA    = 3'd2,
		KIND_ACK     = 3'd3,
		KIND_ILLEGAL = 3'd4
	} kind_t;

	// Classified item passed from the front end to the back end.
	typedef struct packed {
		logic        is_tick;
		kind_t       kind;
		reason_t     form_why;
		logic [31:0] src_addr;
		logic [15:0] src_port;
		logic [15:0] block_in;
		logic        short_data;
		logic        open_ok;
		logic        read_err;
		logic [9:0]  read_bytes;
		logic        write_ok;
	} cls_t;

	// One result item.
	typedef struct packed {
		action_t     action;
		logic [31:0] dest_addr;
		logic [15:0] dest_port;
		logic [15:0] block_out;
		logic [9:0]  data_len;
		logic [2:0]  error_code;
		reason_t     error_reason;
		logic        session_started;
		logic        session_closed;
		logic        write_session;
	} res_t;

	// Configuration register values.
	typedef struct packed {
		logic [15:0] timeout_ticks;
		logic [7:0]  retry_limit;
	} cfg_t;

endpackage

// ===== design/tftp_server_session.sv =====
// ----------------------------------------------------------------------------
// TFTP server session control
// One-session server: packets and timer ticks in, one action per item out.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive an item (decoded packet when mode is 0,
//   timer tick when mode is 1) and raise push; it is taken at an edge where
//   full is low. Result side is a queue too: while empty is low the oldest
//   result is on the output ports, and pop at such an edge takes it.
//   Every item gives exactly one result, in order.
//   An accepted item is registered in the front queue, decided on by the
//   back end and registered in the result queue before it shows on the ports.
//   Throughput is one item per cycle while the result queue has room: a
//   two-entry queue after the decode stage and a two-entry result queue
//   decouple the sides, and the back end session registers update per taken item.
//   When the receiver stalls, the result queue fills, the back end stops,
//   then the front queue fills and full rises; nothing is lost.
//   Reset clears both queues and the session state; timeout_ticks and
//   retry_limit return to 5. Write them through cfg_write only while idle.
// ----------------------------------------------------------------------------
`include "tftp_server_session_defines.svh"

module tftp_server_session #(
	parameter int BLOCK_BYTES = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               push,
	output logic               full,
	input  logic               mode,
	input  logic [15:0]        opcode,
	input  logic [31:0]        src_addr,
	input  logic [15:0]        src_port,
	input  logic [15:0]        block_in,
	input  logic [9:0]         payload_len,
	input  logic [1:0]         request_form,
	input  logic               open_ok,
	input  logic signed [10:0] read_len,
	input  logic               write_ok,
	output logic               empty,
	input  logic               pop,
	output logic [2:0]         action,
	output logic [31:0]        dest_addr,
	output logic [15:0]        dest_port,
	output logic [15:0]        block_out,
	output logic [9:0]         data_len,
	output logic [2:0]         error_code,
	output logic [3:0]         error_reason,
	output logic               session_started,
	output logic               session_closed,
	output logic               write_session
);

	tss_pkg::cfg_t cfg_q;
	tss_pkg::cls_t cls;
	tss_pkg::res_t res;
	logic          cls_valid;
	logic          cls_take;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks <= 16'd5;
			cfg_q.retry_limit   <= 8'd5;
		end else if (cfg_write) begin
			unique case (cfg_index)
				tss_pkg::CFG_TIMEOUT: cfg_q.timeout_ticks <= cfg_data;
				tss_pkg::CFG_RETRY:   cfg_q.retry_limit   <= cfg_data[7:0];
				default:              cfg_q               <= cfg_q;
			endcase
		end
	end

	// Front end: accept and classify.
	tss_front #(
		.BLOCK_BYTES(BLOCK_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.mode        (mode),
		.opcode      (opcode),
		.src_addr    (src_addr),
		.src_port    (src_port),
		.block_in    (block_in),
		.payload_len (payload_len),
		.request_form(request_form),
		.open_ok     (open_ok),
		.read_len    (read_len),
		.write_ok    (write_ok),
		.cls         (cls),
		.cls_valid   (cls_valid),
		.cls_take    (cls_take)
	);

	// Back end: session state and result queue.
	tss_back #(
		.BLOCK_BYTES(BLOCK_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cls      (cls),
		.cls_valid(cls_valid),
		.cls_take (cls_take),
		.res      (res),
		.empty    (empty),
		.pop      (pop)
	);

	assign action          = res.action;
	assign dest_addr       = res.dest_addr;
	assign dest_port       = res.dest_port;
	assign block_out       = res.block_out;
	assign data_len        = res.data_len;
	assign error_code      = res.error_code;
	assign error_reason    = res.error_reason;
	assign session_started = res.session_started;
	assign session_closed  = res.session_closed;
	assign write_session   = res.write_session;

	// An ERROR result always carries a reason and a wire code.
	`TSS_ASSERT_SAME(a_error_has_reason, !empty && (action == tss_pkg::ACT_ERROR), (error_reason != 4'd0) && (error_code != 3'd0))

	// A result with no packet has no destination and no block.
	`TSS_ASSERT_SAME(a_none_is_clear, !empty && (action == tss_pkg::ACT_NONE), (dest_addr == 32'd0) && (dest_port == 16'd0) && (block_out == 16'd0))

	// Opening and closing together only happens on a read failure.
	`TSS_ASSERT_SAME(a_open_close_read_fail, !empty && session_started && session_closed, error_reason == tss_pkg::WHY_READ_FAIL)

	// A result held back by the receiver stays put.
	`TSS_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(res))

endmodule

// ===== design/tss_fifo.sv =====
// ----------------------------------------------------------------------------
// Small register queue
// First-in first-out store of a few items, the oldest shown on rdata.
// ----------------------------------------------------------------------------
module tss_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [AW:0] FULL_COUNT = (AW + 1)'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == FULL_COUNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Storage is payload only and needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/tss_front.sv =====
// ----------------------------------------------------------------------------
// TFTP session front end
// Accepts items, decodes opcode and file layer results, and queues them.
// ----------------------------------------------------------------------------
module tss_front #(
	parameter int BLOCK_BYTES = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               mode,
	input  logic [15:0]        opcode,
	input  logic [31:0]        src_addr,
	input  logic [15:0]        src_port,
	input  logic [15:0]        block_in,
	input  logic [9:0]         payload_len,
	input  logic [1:0]         request_form,
	input  logic               open_ok,
	input  logic signed [10:0] read_len,
	input  logic               write_ok,
	output tss_pkg::cls_t      cls,
	output logic               cls_valid,
	input  logic               cls_take
);

	localparam logic [16:0] BB = 17'(BLOCK_BYTES);

	tss_pkg::cls_t           cls_in;
	logic [$bits(cls_in)-1:0] cls_bits;
	logic                     q_empty;

	// Classify the incoming item.
	always_comb begin
		cls_in            = '0;
		cls_in.is_tick    = mode;
		cls_in.src_addr   = src_addr;
		cls_in.src_port   = src_port;
		cls_in.block_in   = block_in;
		cls_in.open_ok    = open_ok;
		cls_in.write_ok   = write_ok;
		cls_in.short_data = ({7'd0, payload_len} < BB);
		cls_in.read_err   = read_len[10];
		if ({7'd0, read_len[9:0]} > BB) begin
			cls_in.read_bytes = BB[9:0];
		end else begin
			cls_in.read_bytes = read_len[9:0];
		end
		unique case (request_form)
			tss_pkg::FORM_OK:        cls_in.form_why = tss_pkg::WHY_NONE;
			tss_pkg::FORM_NAME_LONG: cls_in.form_why = tss_pkg::WHY_NAME_LONG;
			default:                 cls_in.form_why = tss_pkg::WHY_MODE_LONG;
		endcase
		unique case (opcode)
			tss_pkg::OP_RRQ:  cls_in.kind = tss_pkg::KIND_RRQ;
			tss_pkg::OP_WRQ:  cls_in.kind = tss_pkg::KIND_WRQ;
			tss_pkg::OP_DATA: cls_in.kind = tss_pkg::KIND_DATA;
			tss_pkg::OP_ACK:  cls_in.kind = tss_pkg::KIND_ACK;
			default:          cls_in.kind = tss_pkg::KIND_ILLEGAL;
		endcase
	end

	// Queue between the front and back ends.
	tss_fifo #(
		.WIDTH($bits(cls_in)),
		.DEPTH(2)
	) u_cls_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cls_in),
		.full  (full),
		.pop   (cls_take),
		.rdata (cls_bits),
		.empty (q_empty)
	);

	assign cls       = tss_pkg::cls_t'(cls_bits);
	assign cls_valid = !q_empty;

endmodule

// ===== design/tss_back.sv =====
// ----------------------------------------------------------------------------
// TFTP session back end
// Holds the session state, decides one action per item and queues results.
// ----------------------------------------------------------------------------
module tss_back #(
	parameter int BLOCK_BYTES = 512
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tss_pkg::cfg_t cfg,
	input  tss_pkg::cls_t cls,
	input  logic          cls_valid,
	output logic          cls_take,
	output tss_pkg::res_t res,
	output logic          empty,
	input  logic          pop
);

	localparam logic [16:0] BB = 17'(BLOCK_BYTES);

	// Session state.
	logic        open_q;
	logic [31:0] peer_addr_q;
	logic [15:0] peer_port_q;
	logic        is_write_q;
	logic [15:0] cur_block_q;
	logic        have_last_q;
	logic [9:0]  last_bytes_q;
	logic [31:0] elapsed_q;
	logic [7:0]  retry_q;

	logic        open_d;
	logic [31:0] peer_addr_d;
	logic [15:0] peer_port_d;
	logic        is_write_d;
	logic [15:0] cur_block_d;
	logic        have_last_d;
	logic [9:0]  last_bytes_d;
	logic [31:0] elapsed_d;
	logic [7:0]  retry_d;

	tss_pkg::res_t           res_d;
	logic [$bits(res_d)-1:0] res_bits;
	logic                    out_full;
	logic                    foreign;
	logic                    want_block;
	logic [15:0]             blk_sel;

	assign cls_take = cls_valid && !out_full;
	assign foreign  = ((peer_port_q != '0) && (cls.src_port != peer_port_q)) ||
	                  ((peer_addr_q != '0) && (cls.src_addr != peer_addr_q));

	// Decision logic for the item at the head of the queue.
	always_comb begin
		open_d       = open_q;
		peer_addr_d  = peer_addr_q;
		peer_port_d  = peer_port_q;
		is_write_d   = is_write_q;
		cur_block_d  = cur_block_q;
		have_last_d  = have_last_q;
		last_bytes_d = last_bytes_q;
		elapsed_d    = elapsed_q;
		retry_d      = retry_q;
		res_d        = '0;
		want_block   = 1'b0;
		blk_sel      = cur_block_q;

		if (cls.is_tick) begin
			// Timer tick: resend the stored block or give up.
			elapsed_d = elapsed_q + 32'd1;
			if (open_q && (elapsed_d > {16'd0, cfg.timeout_ticks})) begin
				if (have_last_q && (retry_q < cfg.retry_limit)) begin
					res_d.action    = tss_pkg::ACT_RESEND;
					res_d.dest_addr = peer_addr_q;
					res_d.dest_port = peer_port_q;
					res_d.block_out = cur_block_q;
					res_d.data_len  = last_bytes_q;
					retry_d         = retry_q + 8'd1;
				end else begin
					res_d.session_closed = 1'b1;
				end
			end
		end else if (foreign) begin
			res_d.action       = tss_pkg::ACT_ERROR;
			res_d.dest_addr    = cls.src_addr;
			res_d.dest_port    = cls.src_port;
			res_d.error_code   = tss_pkg::ECODE_ACCESS;
			res_d.error_reason = tss_pkg::WHY_BUSY;
		end else begin
			elapsed_d = '0;
			retry_d   = '0;
			case (cls.kind) inside
				tss_pkg::KIND_RRQ, tss_pkg::KIND_WRQ: begin
					if (open_q) begin
						res_d.action       = tss_pkg::ACT_ERROR;
						res_d.error_code   = tss_pkg::ECODE_ACCESS;
						res_d.error_reason = tss_pkg::WHY_BUSY;
					end else if (cls.form_why != tss_pkg::WHY_NONE) begin
						res_d.action       = tss_pkg::ACT_ERROR;
						res_d.error_code   = tss_pkg::ECODE_ACCESS;
						res_d.error_reason = cls.form_why;
					end else begin
						cur_block_d = 16'd1;
						if (!cls.open_ok) begin
							res_d.action       = tss_pkg::ACT_ERROR;
							res_d.error_code   = tss_pkg::ECODE_NOT_FOUND;
							res_d.error_reason = tss_pkg::WHY_OPEN_FAIL;
						end else begin
							open_d                = 1'b1;
							peer_addr_d           = cls.src_addr;
							peer_port_d           = cls.src_port;
							res_d.session_started = 1'b1;
							if (cls.kind == tss_pkg::KIND_WRQ) begin
								is_write_d      = 1'b1;
								res_d.action    = tss_pkg::ACT_ACK;
								res_d.dest_addr = cls.src_addr;
								res_d.dest_port = cls.src_port;
							end else begin
								is_write_d = 1'b0;
								want_block = 1'b1;
								blk_sel    = 16'd1;
							end
						end
					end
				end
				tss_pkg::KIND_DATA: begin
					if (!open_q) begin
						res_d.action       = tss_pkg::ACT_ERROR;
						res_d.error_code   = tss_pkg::ECODE_ACCESS;
						res_d.error_reason = tss_pkg::WHY_NO_SESSION;
					end else if (!is_write_q) begin
						res_d.action       = tss_pkg::ACT_ERROR;
						res_d.error_code   = tss_pkg::ECODE_ACCESS;
						res_d.error_reason = tss_pkg::WHY_NOT_WRITE;
					end else begin
						if (!cls.write_ok) begin
							res_d.action         = tss_pkg::ACT_ERROR;
							res_d.error_code     = tss_pkg::ECODE_ACCESS;
							res_d.error_reason   = tss_pkg::WHY_WRITE_FAIL;
							res_d.session_closed = 1'b1;
						end else begin
							res_d.action    = tss_pkg::ACT_ACK;
							res_d.dest_addr = peer_addr_q;
							res_d.dest_port = peer_port_q;
							res_d.block_out = cls.block_in;
						end
						if (cls.short_data) begin
							res_d.session_closed = 1'b1;
						end
					end
				end
				tss_pkg::KIND_ACK: begin
					if (!open_q) begin
						res_d.action       = tss_pkg::ACT_ERROR;
						res_d.error_code   = tss_pkg::ECODE_ACCESS;
						res_d.error_reason = tss_pkg::WHY_NO_SESSION;
					end else if (is_write_q) begin
						res_d.action       = tss_pkg::ACT_ERROR;
						res_d.error_code   = tss_pkg::ECODE_ACCESS;
						res_d.error_reason = tss_pkg::WHY_NOT_READ;
					end else if (cls.block_in != cur_block_q) begin
						res_d.action       = tss_pkg::ACT_ERROR;
						res_d.error_code   = tss_pkg::ECODE_UNKNOWN_ID;
						res_d.error_reason = tss_pkg::WHY_WRONG_BLOCK;
					end else if (have_last_q && ({7'd0, last_bytes_q} != BB)) begin
						res_d.session_closed = 1'b1;
					end else begin
						cur_block_d = cur_block_q + 16'd1;
						want_block  = 1'b1;
						blk_sel     = cur_block_d;
					end
				end
				default: begin
					res_d.action       = tss_pkg::ACT_ERROR;
					res_d.error_code   = tss_pkg::ECODE_ILLEGAL;
					res_d.error_reason = tss_pkg::WHY_UNKNOWN_OP;
				end
			endcase

			// Fetch of the next data block: send it, or fail and close.
			if (want_block) begin
				if (cls.read_err) begin
					res_d.action         = tss_pkg::ACT_ERROR;
					res_d.error_code     = tss_pkg::ECODE_ACCESS;
					res_d.error_reason   = tss_pkg::WHY_READ_FAIL;
					res_d.session_closed = 1'b1;
				end else begin
					have_last_d     = 1'b1;
					last_bytes_d    = cls.read_bytes;
					res_d.action    = tss_pkg::ACT_DATA;
					res_d.dest_addr = peer_addr_d;
					res_d.dest_port = peer_port_d;
					res_d.block_out = blk_sel;
					res_d.data_len  = cls.read_bytes;
				end
			end

			// Errors always go back to the packet source.
			if (res_d.action == tss_pkg::ACT_ERROR) begin
				res_d.dest_addr = cls.src_addr;
				res_d.dest_port = cls.src_port;
			end
		end

		// A close drops the peer and the stored block.
		if (res_d.session_closed) begin
			open_d       = 1'b0;
			peer_addr_d  = '0;
			peer_port_d  = '0;
			have_last_d  = 1'b0;
			last_bytes_d = '0;
		end
		res_d.write_session = is_write_d;
	end

	// State update when an item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q       <= 1'b0;
			peer_addr_q  <= '0;
			peer_port_q  <= '0;
			is_write_q   <= 1'b0;
			cur_block_q  <= '0;
			have_last_q  <= 1'b0;
			last_bytes_q <= '0;
			elapsed_q    <= '0;
			retry_q      <= '0;
		end else if (cls_take) begin
			open_q       <= open_d;
			peer_addr_q  <= peer_addr_d;
			peer_port_q  <= peer_port_d;
			is_write_q   <= is_write_d;
			cur_block_q  <= cur_block_d;
			have_last_q  <= have_last_d;
			last_bytes_q <= last_bytes_d;
			elapsed_q    <= elapsed_d;
			retry_q      <= retry_d;
		end
	end

	// Result queue towards the receiver.
	tss_fifo #(
		.WIDTH($bits(res_d)),
		.DEPTH(2)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cls_take),
		.wdata (res_d),
		.full  (out_full),
		.pop   (pop),
		.rdata (res_bits),
		.empty (empty)
	);

	assign res = tss_pkg::res_t'(res_bits);

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// TFTP server session testbench
// Drives decoded packets and timer ticks into the session block through its
// queue ports. The receiver stalls at random, and a scoreboard predicts every
// result from its own copy of the session state and compares each field.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          BLOCK_BYTES  = 512;
	localparam int unsigned CYCLE_LIMIT  = 1000000;
	localparam int          DRAIN_CYCLES = 8;
	localparam int          PHASE_ITEMS  = 105;
	localparam int          PHASES       = 8;

	// Values that the package does not name.
	localparam logic [1:0]  FORM_MODE_LONG = 2'd2;
	localparam logic [1:0]  FORM_UNUSED    = 2'd3;
	localparam logic [15:0] OP_ZERO        = 16'h0000;
	localparam logic [15:0] OP_TOP         = 16'hFFFF;
	localparam logic [10:0] READ_ERROR     = 11'h7FF;
	localparam logic [10:0] READ_OVERSIZE  = 11'h3FF;

	localparam logic [31:0] HOST_A   = 32'hC0A8_0A21;
	localparam logic [31:0] HOST_B   = 32'h0A00_0007;
	localparam logic [31:0] HOST_MAX = 32'hFFFF_FFFF;
	localparam logic [15:0] PORT_A   = 16'd1069;
	localparam logic [15:0] PORT_B   = 16'd40000;
	localparam logic [15:0] PORT_MAX = 16'hFFFF;

	// One input item as it goes onto the ports.
	typedef struct {
		logic               mode;
		logic [15:0]        opcode;
		logic [31:0]        src_addr;
		logic [15:0]        src_port;
		logic [15:0]        block_in;
		logic [9:0]         payload_len;
		logic [1:0]         request_form;
		logic               open_ok;
		logic signed [10:0] read_len;
		logic               write_ok;
	} session_item_t;

	// Session state mirror and the queue of replies still to come.
	class session_scoreboard;
		bit [15:0]     timeout_ticks;
		bit [7:0]      retry_limit;
		bit            live;
		bit [31:0]     peer_addr;
		bit [15:0]     peer_port;
		bit            is_write;
		bit [15:0]     cur_block;
		bit            have_data;
		bit [9:0]      data_bytes;
		bit [31:0]     ticks;
		bit [31:0]     last_rx_tick;
		bit [7:0]      retries;
		tss_pkg::res_t nxt;
		tss_pkg::res_t reply_q[$];
		int            faults;

		function new();
			timeout_ticks = 16'd5;
			retry_limit   = 8'd5;
			live          = 1'b0;
			peer_addr     = '0;
			peer_port     = '0;
			is_write      = 1'b0;
			cur_block     = '0;
			have_data     = 1'b0;
			data_bytes    = '0;
			ticks         = '0;
			last_rx_tick  = '0;
			retries       = '0;
			faults        = 0;
		endfunction

		function void set_register(logic idx, logic [15:0] val);
			if (idx == tss_pkg::CFG_TIMEOUT) begin
				timeout_ticks = val;
			end else begin
				retry_limit = val[7:0];
			end
		endfunction

		function int pending();
			return reply_q.size();
		endfunction

		// Closing forgets the peer and the stored block, but not the direction.
		function void end_session();
			live       = 1'b0;
			peer_addr  = '0;
			peer_port  = '0;
			have_data  = 1'b0;
			data_bytes = '0;
			nxt.session_closed = 1'b1;
		endfunction

		function void refuse(logic [31:0] sa, logic [15:0] sp, logic [2:0] code,
				tss_pkg::reason_t why);
			nxt.action       = tss_pkg::ACT_ERROR;
			nxt.dest_addr    = sa;
			nxt.dest_port    = sp;
			nxt.block_out    = '0;
			nxt.data_len     = '0;
			nxt.error_code   = code;
			nxt.error_reason = why;
		endfunction

		function void reply(tss_pkg::action_t act, logic [15:0] blk, logic [9:0] len);
			nxt.action    = act;
			nxt.dest_addr = peer_addr;
			nxt.dest_port = peer_port;
			nxt.block_out = blk;
			nxt.data_len  = len;
		endfunction

		// Read the next block and send it, or fail the read and close.
		function void send_block(logic [10:0] rl, logic [31:0] sa, logic [15:0] sp);
			bit [9:0] n;
			if (rl[10]) begin
				refuse(sa, sp, tss_pkg::ECODE_ACCESS, tss_pkg::WHY_READ_FAIL);
				end_session();
				return;
			end
			n = rl[9:0];
			if (n > BLOCK_BYTES) n = 10'(BLOCK_BYTES);
			have_data  = 1'b1;
			data_bytes = n;
			reply(tss_pkg::ACT_DATA, cur_block, n);
		endfunction

		// Work out the reply to one accepted item and queue it.
		function void note_item(session_item_t it);
			nxt = '0;
			if (it.mode) begin
				ticks = ticks + 32'd1;
				if (live && (ticks - last_rx_tick) > timeout_ticks) begin
					if (have_data && retries < retry_limit) begin
						reply(tss_pkg::ACT_RESEND, cur_block, data_bytes);
						retries = retries + 8'd1;
					end else begin
						end_session();
					end
				end
			end else if ((peer_port != 0 && it.src_port != peer_port) ||
					(peer_addr != 0 && it.src_addr != peer_addr)) begin
				refuse(it.src_addr, it.src_port, tss_pkg::ECODE_ACCESS, tss_pkg::WHY_BUSY);
			end else begin
				last_rx_tick = ticks;
				retries      = '0;
				case (it.opcode) inside
					tss_pkg::OP_RRQ, tss_pkg::OP_WRQ: begin
						if (live) begin
							refuse(it.src_addr, it.src_port, tss_pkg::ECODE_ACCESS,
								tss_pkg::WHY_BUSY);
						end else if (it.request_form == tss_pkg::FORM_NAME_LONG) begin
							refuse(it.src_addr, it.src_port, tss_pkg::ECODE_ACCESS,
								tss_pkg::WHY_NAME_LONG);
						end else if (it.request_form != tss_pkg::FORM_OK) begin
							refuse(it.src_addr, it.src_port, tss_pkg::ECODE_ACCESS,
								tss_pkg::WHY_MODE_LONG);
						end else begin
							cur_block = 16'd1;
							if (!it.open_ok) begin
								refuse(it.src_addr, it.src_port, tss_pkg::ECODE_NOT_FOUND,
									tss_pkg::WHY_OPEN_FAIL);
							end else begin
								live      = 1'b1;
								peer_addr = it.src_addr;
								peer_port = it.src_port;
								nxt.session_started = 1'b1;
								if (it.opcode == tss_pkg::OP_WRQ) begin
									is_write = 1'b1;
									reply(tss_pkg::ACT_ACK, '0, '0);
								end else begin
									is_write = 1'b0;
									send_block(it.read_len, it.src_addr, it.src_port);
								end
							end
						end
					end
					tss_pkg::OP_DATA: begin
						if (!live) begin
							refuse(it.src_addr, it.src_port, tss_pkg::ECODE_ACCESS,
								tss_pkg::WHY_NO_SESSION);
						end else if (!is_write) begin
							refuse(it.src_addr, it.src_port, tss_pkg::ECODE_ACCESS,
								tss_pkg::WHY_NOT_WRITE);
						end else begin
							if (!it.write_ok) begin
								refuse(it.src_addr, it.src_port, tss_pkg::ECODE_ACCESS,
									tss_pkg::WHY_WRITE_FAIL);
								end_session();
							end else begin
								reply(tss_pkg::ACT_ACK, it.block_in, '0);
							end
							if (it.payload_len < BLOCK_BYTES) end_session();
						end
					end
					tss_pkg::OP_ACK: begin
						if (!live) begin
							refuse(it.src_addr, it.src_port, tss_pkg::ECODE_ACCESS,
								tss_pkg::WHY_NO_SESSION);
						end else if (is_write) begin
							refuse(it.src_addr, it.src_port, tss_pkg::ECODE_ACCESS,
								tss_pkg::WHY_NOT_READ);
						end else if (it.block_in != cur_block) begin
							refuse(it.src_addr, it.src_port, tss_pkg::ECODE_UNKNOWN_ID,
								tss_pkg::WHY_WRONG_BLOCK);
						end else if (have_data && data_bytes != BLOCK_BYTES) begin
							end_session();
						end else begin
							cur_block = cur_block + 16'd1;
							send_block(it.read_len, it.src_addr, it.src_port);
						end
					end
					default: begin
						refuse(it.src_addr, it.src_port, tss_pkg::ECODE_ILLEGAL,
							tss_pkg::WHY_UNKNOWN_OP);
					end
				endcase
			end
			nxt.write_session = is_write;
			reply_q.push_back(nxt);
		endfunction

		function string show(tss_pkg::res_t r);
			return $sformatf({"action %0d to %h:%h block %0d len %0d code %0d why %0d",
				" st %b cl %b wr %b"},
				r.action, r.dest_addr, r.dest_port, r.block_out, r.data_len,
				r.error_code, r.error_reason, r.session_started, r.session_closed,
				r.write_session);
		endfunction

		// Compare one popped result with the oldest reply waiting.
		function void check_result(tss_pkg::res_t got);
			tss_pkg::res_t want;
			if (reply_q.size() == 0) begin
				faults++;
				if (faults <= 10) begin
					$display("%0t: result with nothing expected: %s", $time, show(got));
				end
				return;
			end
			want = reply_q.pop_front();
			if (got !== want) begin
				faults++;
				if (faults <= 10) begin
					$display("%0t: mismatch", $time);
					$display("  expected %s", show(want));
					$display("  actual   %s", show(got));
				end
			end
		endfunction
	endclass

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               cfg_write    = 1'b0;
	logic               cfg_index    = 1'b0;
	logic [15:0]        cfg_data     = '0;
	logic               push         = 1'b0;
	logic               full;
	logic               mode         = 1'b0;
	logic [15:0]        opcode       = '0;
	logic [31:0]        src_addr     = '0;
	logic [15:0]        src_port     = '0;
	logic [15:0]        block_in     = '0;
	logic [9:0]         payload_len  = '0;
	logic [1:0]         request_form = '0;
	logic               open_ok      = 1'b0;
	logic signed [10:0] read_len     = '0;
	logic               write_ok     = 1'b0;
	logic               empty;
	logic               pop          = 1'b0;
	logic [2:0]         action;
	logic [31:0]        dest_addr;
	logic [15:0]        dest_port;
	logic [15:0]        block_out;
	logic [9:0]         data_len;
	logic [2:0]         error_code;
	logic [3:0]         error_reason;
	logic               session_started;
	logic               session_closed;
	logic               write_session;

	session_scoreboard sb;
	bit                tx_idle = 1'b1;
	bit                rx_idle = 1'b1;
	int                sent    = 0;
	int                rx_stall = 0;
	int unsigned       cycle_count = 0;
	tss_pkg::res_t     rx_result;

	int unsigned timeout_set[PHASES] = '{5, 1, 2, 65535, 3, 1, 4, 7};
	int unsigned retry_set[PHASES]   = '{5, 0, 1, 255, 3, 255, 2, 0};

	tftp_server_session #(
		.BLOCK_BYTES(BLOCK_BYTES)
	) i_dut (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	// Mostly short pauses, now and then a long one.
	function automatic int rx_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (!rx_idle || roll < 60) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int tx_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (!tx_idle || roll < 55) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// Run limit: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** tftp_server_session: FAILED **");
			$finish;
		end
	end

	// Result side: take results when pop is high, stalling at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				rx_result = {action, dest_addr, dest_port, block_out, data_len, error_code,
					error_reason, session_started, session_closed, write_session};
				sb.check_result(rx_result);
			end
			if (rx_stall > 0) begin
				pop <= 1'b0;
				rx_stall--;
			end else begin
				pop <= 1'b1;
				rx_stall = rx_gap();
			end
		end
	end

	// Offer one item and wait until the block takes it.
	task automatic send(session_item_t it);
		int gap;
		gap = tx_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push         <= 1'b1;
		mode         <= it.mode;
		opcode       <= it.opcode;
		src_addr     <= it.src_addr;
		src_port     <= it.src_port;
		block_in     <= it.block_in;
		payload_len  <= it.payload_len;
		request_form <= it.request_form;
		open_ok      <= it.open_ok;
		read_len     <= it.read_len;
		write_ok     <= it.write_ok;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_item(it);
		sent++;
	endtask

	// Hold the sender until every reply has come and the block is quiet.
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(int unsigned tmo, int unsigned rty);
		drain();
		cfg_write <= 1'b1;
		cfg_index <= tss_pkg::CFG_TIMEOUT;
		cfg_data  <= 16'(tmo);
		@(posedge clk);
		sb.set_register(tss_pkg::CFG_TIMEOUT, 16'(tmo));
		cfg_index <= tss_pkg::CFG_RETRY;
		cfg_data  <= {8'($urandom), 8'(rty)};
		@(posedge clk);
		sb.set_register(tss_pkg::CFG_RETRY, 16'(rty));
		cfg_write <= 1'b0;
	endtask

	function automatic session_item_t make_pkt(logic [15:0] op, logic [31:0] sa,
			logic [15:0] sp);
		session_item_t it;
		it.mode         = 1'b0;
		it.opcode       = op;
		it.src_addr     = sa;
		it.src_port     = sp;
		it.block_in     = 16'($urandom);
		it.payload_len  = 10'(BLOCK_BYTES);
		it.request_form = tss_pkg::FORM_OK;
		it.open_ok      = 1'b1;
		it.read_len     = 11'(BLOCK_BYTES);
		it.write_ok     = 1'b1;
		return it;
	endfunction

	// A tick ignores the packet fields, so they carry noise.
	function automatic session_item_t make_tick();
		session_item_t it;
		it.mode         = 1'b1;
		it.opcode       = 16'($urandom);
		it.src_addr     = $urandom;
		it.src_port     = 16'($urandom);
		it.block_in     = 16'($urandom);
		it.payload_len  = 10'($urandom);
		it.request_form = 2'($urandom);
		it.open_ok      = 1'($urandom);
		it.read_len     = 11'($urandom);
		it.write_ok     = 1'($urandom);
		return it;
	endfunction

	function automatic logic [10:0] block_read_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 80) return 11'(BLOCK_BYTES);
		if (roll < 88) return 11'($urandom_range(0, BLOCK_BYTES - 1));
		if (roll < 94) return 11'($urandom_range(BLOCK_BYTES + 1, 1023));
		return 11'($urandom_range(1024, 2047));
	endfunction

	function automatic logic [9:0] data_payload();
		if ($urandom_range(0, 99) < 85) return 10'(BLOCK_BYTES);
		return 10'($urandom_range(0, 1023));
	endfunction

	task automatic pick_client(output logic [31:0] ca, output logic [15:0] cp);
		ca = ($urandom_range(0, 15) == 0) ? 32'h0 : $urandom;
		cp = ($urandom_range(0, 15) == 0) ? 16'h0 : 16'($urandom_range(1, 65535));
	endtask

	// A packet that a live session should refuse or that breaks the transfer.
	function automatic session_item_t broken_item(logic [31:0] ca, logic [15:0] cp);
		session_item_t it;
		case ($urandom_range(0, 6))
			0: begin
				it = make_pkt(16'($urandom_range(tss_pkg::OP_RRQ, tss_pkg::OP_ACK)), ca, cp);
				if ($urandom_range(0, 1)) it.src_addr = ca ^ (32'd1 << $urandom_range(0, 31));
				else it.src_port = cp ^ (16'd1 << $urandom_range(0, 15));
			end
			1: it = make_pkt($urandom_range(0, 1) ? tss_pkg::OP_RRQ : tss_pkg::OP_WRQ, ca, cp);
			2: it = make_pkt(sb.is_write ? tss_pkg::OP_ACK : tss_pkg::OP_DATA, ca, cp);
			3: begin
				it = make_pkt(tss_pkg::OP_ACK, ca, cp);
				it.block_in = sb.cur_block ^ (16'd1 << $urandom_range(0, 15));
			end
			4: begin
				it = make_pkt(16'($urandom), ca, cp);
				if (it.opcode >= tss_pkg::OP_RRQ && it.opcode <= tss_pkg::OP_ACK) begin
					it.opcode = it.opcode + 16'h0100;
				end
			end
			5: begin
				it = make_pkt(sb.is_write ? tss_pkg::OP_DATA : tss_pkg::OP_ACK, ca, cp);
				it.block_in = sb.cur_block;
				it.read_len = 11'($urandom_range(1024, 2047));
				it.write_ok = 1'b0;
			end
			default: begin
				it = make_pkt(sb.is_write ? tss_pkg::OP_DATA : tss_pkg::OP_ACK, ca, cp);
				it.payload_len = 10'($urandom_range(0, 1023));
			end
		endcase
		return it;
	endfunction

	// Short runs of ticks mostly, sometimes long enough to use up the retries.
	task automatic tick_burst();
		int span;
		int n;
		span = int'(sb.timeout_ticks) + int'(sb.retry_limit) + 3;
		if (span > 300) span = 300;
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, span) : $urandom_range(1, 3);
		repeat (n) send(make_tick());
	endtask

	// Finish a session from its peer with a short block.
	task automatic close_out(logic [31:0] ca, logic [15:0] cp);
		session_item_t it;
		while (sb.live) begin
			if (sb.is_write) begin
				it = make_pkt(tss_pkg::OP_DATA, ca, cp);
				it.payload_len = 10'($urandom_range(0, BLOCK_BYTES - 1));
			end else begin
				it = make_pkt(tss_pkg::OP_ACK, ca, cp);
				it.block_in = sb.cur_block;
				it.read_len = 11'($urandom_range(0, BLOCK_BYTES - 1));
			end
			send(it);
		end
	endtask

	task automatic read_session();
		logic [31:0]   ca;
		logic [15:0]   cp;
		session_item_t it;
		int            steps;
		int            roll;
		pick_client(ca, cp);
		it = make_pkt(tss_pkg::OP_RRQ, ca, cp);
		it.read_len = block_read_len();
		if ($urandom_range(0, 15) == 0) it.open_ok = 1'b0;
		send(it);
		steps = $urandom_range(2, 24);
		while (sb.live && steps > 0) begin
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				it = make_pkt(tss_pkg::OP_ACK, ca, cp);
				it.block_in = sb.cur_block;
				it.read_len = block_read_len();
				send(it);
			end else if (roll < 82) begin
				tick_burst();
			end else begin
				send(broken_item(ca, cp));
			end
			steps--;
		end
		close_out(ca, cp);
	endtask

	task automatic write_session_run();
		logic [31:0]   ca;
		logic [15:0]   cp;
		logic [15:0]   blk;
		session_item_t it;
		int            steps;
		int            roll;
		pick_client(ca, cp);
		it = make_pkt(tss_pkg::OP_WRQ, ca, cp);
		if ($urandom_range(0, 15) == 0) it.open_ok = 1'b0;
		send(it);
		blk = 16'd1;
		steps = $urandom_range(2, 24);
		while (sb.live && steps > 0) begin
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				it = make_pkt(tss_pkg::OP_DATA, ca, cp);
				it.block_in    = blk;
				it.payload_len = data_payload();
				it.write_ok    = ($urandom_range(0, 24) != 0);
				send(it);
				blk++;
			end else if (roll < 82) begin
				tick_burst();
			end else begin
				send(broken_item(ca, cp));
			end
			steps--;
		end
		close_out(ca, cp);
	endtask

	// Stray packets and ticks with no session; requests here never open one.
	task automatic stray_items();
		session_item_t it;
		repeat ($urandom_range(1, 6)) begin
			if ($urandom_range(0, 3) == 0) begin
				it = make_tick();
			end else begin
				it = make_tick();
				it.mode = 1'b0;
				if ($urandom_range(0, 4) != 0) begin
					it.opcode = 16'($urandom_range(tss_pkg::OP_RRQ, tss_pkg::OP_ACK));
				end
				if (it.opcode == tss_pkg::OP_RRQ || it.opcode == tss_pkg::OP_WRQ) begin
					if ($urandom_range(0, 1)) it.request_form = 2'($urandom_range(1, 3));
					else it.open_ok = 1'b0;
				end
			end
			send(it);
		end
	endtask

	// Directed items: field extremes, every opcode and the corner cases.
	task automatic directed_items();
		session_item_t it;
		send(make_pkt(tss_pkg::OP_ACK, HOST_A, PORT_A));
		send(make_pkt(OP_ZERO, HOST_A, PORT_A));
		send(make_pkt(OP_TOP, 32'h0, 16'h0));
		it = make_pkt(tss_pkg::OP_RRQ, HOST_A, PORT_A);
		it.request_form = tss_pkg::FORM_NAME_LONG;
		send(it);
		it = make_pkt(tss_pkg::OP_WRQ, HOST_A, PORT_A);
		it.request_form = FORM_MODE_LONG;
		send(it);
		it = make_pkt(tss_pkg::OP_RRQ, HOST_A, PORT_A);
		it.request_form = FORM_UNUSED;
		send(it);
		it = make_pkt(tss_pkg::OP_RRQ, HOST_A, PORT_A);
		it.open_ok = 1'b0;
		send(it);
		// Read error on the request opens and closes in one item.
		it = make_pkt(tss_pkg::OP_RRQ, HOST_A, PORT_A);
		it.read_len = READ_ERROR;
		send(it);
		// Read session from the all-ones host; the first read is oversized.
		it = make_pkt(tss_pkg::OP_RRQ, HOST_MAX, PORT_MAX);
		it.read_len = READ_OVERSIZE;
		send(it);
		send(make_pkt(tss_pkg::OP_ACK, HOST_MAX, PORT_A));
		send(make_pkt(tss_pkg::OP_WRQ, HOST_MAX, PORT_MAX));
		send(make_pkt(tss_pkg::OP_DATA, HOST_MAX, PORT_MAX));
		it = make_pkt(tss_pkg::OP_ACK, HOST_MAX, PORT_MAX);
		it.block_in = 16'hFFFF;
		send(it);
		it.block_in = 16'd1;
		it.read_len = '0;
		send(it);
		it.block_in = 16'd2;
		send(it);
		// Write session from address and port zero accepts any source.
		send(make_pkt(tss_pkg::OP_WRQ, 32'h0, 16'h0));
		it = make_pkt(tss_pkg::OP_DATA, HOST_A, PORT_MAX);
		it.block_in = 16'hFFFF;
		send(it);
		send(make_pkt(tss_pkg::OP_ACK, HOST_A, PORT_A));
		it = make_pkt(tss_pkg::OP_DATA, HOST_A, PORT_A);
		it.write_ok = 1'b0;
		send(it);
		// A write session with nothing stored times out and closes quietly.
		send(make_pkt(tss_pkg::OP_WRQ, HOST_B, PORT_B));
		repeat (6) send(make_tick());
	endtask

	initial begin
		int target;
		int roll;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_items();

		// Random sessions under a series of timer and retry settings.
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) configure(timeout_set[ph], retry_set[ph]);
			target = sent + PHASE_ITEMS;
			while (sent < target) begin
				tx_idle = ($urandom_range(0, 5) != 0);
				rx_idle = ($urandom_range(0, 5) != 0);
				roll = $urandom_range(0, 9);
				if (roll < 4) read_session();
				else if (roll < 8) write_session_run();
				else stray_items();
			end
		end

		drain();
		if (sb.faults == 0) begin
			$display("** tftp_server_session: PASSED **");
		end else begin
			$display("** tftp_server_session: FAILED **");
		end
		$finish;
	end
endmodule
